/* rtl/dss_pkg.sv */
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the seek distance scheduler: register codes,
// sweep modes, sequencer states and the fixed field widths of the channels.
// ----------------------------------------------------------------------------
package dss_pkg;

	// fixed channel field widths
	localparam int unsigned CYL_IN_W   = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned SEEK_W     = 23;
	localparam int unsigned COUNT_W    = 7;

	// saturation limits of the result fields
	localparam logic [SEEK_W-1:0]  SEEK_MAX  = 23'h7F_FFFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

	// reset value of the disk end register
	localparam logic [CFG_DATA_W-1:0] DISK_END_RST = 16'd499;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISK_END   = 2'd2;

	// sweep modes
	typedef enum logic [1:0] {
		MODE_SCAN  = 2'd0,
		MODE_LOOK  = 2'd1,
		MODE_CSCAN = 2'd2,
		MODE_CLOOK = 2'd3
	} mode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_SPLIT,
		ST_UP,
		ST_SWEEP,
		ST_JUMP,
		ST_LOW,
		ST_RESULT
	} state_t;

	// control of the shared distance unit
	typedef struct packed {
		logic acc;
		logic clr;
	} leg_ctl_t;

endpackage

/* rtl/dss_if.sv */
// ----------------------------------------------------------------------------
// dss channel interfaces
// Valid/ready channels of the seek distance scheduler: request input,
// result output and configuration write.
// ----------------------------------------------------------------------------

// request channel
interface dss_req_if import dss_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CYL_IN_W-1:0] cylinder;
	logic                last_request;

	modport source (output valid, output cylinder, output last_request, input ready);
	modport sink (input valid, input cylinder, input last_request, output ready);
endinterface

// result channel
interface dss_res_if import dss_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SEEK_W-1:0]  total_seek;
	logic [COUNT_W-1:0] served_count;
	logic               overflow;

	modport source (output valid, output total_seek, output served_count, output overflow,
		input ready);
	modport sink (input valid, input total_seek, input served_count, input overflow,
		output ready);
endinterface

// configuration write channel
interface dss_cfg_if import dss_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/dss_store.sv */
// ----------------------------------------------------------------------------
// dss_store
// Request store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dss_store #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned DW    = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/dss_leg_unit.sv */
// ----------------------------------------------------------------------------
// dss_leg_unit
// Shared subtractor: gives a < b for the sequencer's compares and adds the
// absolute distance |a - b| into the saturating seek total.
// ----------------------------------------------------------------------------
module dss_leg_unit import dss_pkg::*; #(
	parameter int unsigned HW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  leg_ctl_t          ctl,
	input  logic [HW-1:0]     a,
	input  logic [HW-1:0]     b,
	output logic              lt,
	output logic [SEEK_W-1:0] total
);

	localparam int unsigned SW = ((HW > SEEK_W) ? HW : SEEK_W) + 1;

	logic [HW:0]         diff;
	logic [HW-1:0]       absd;
	logic [SW-1:0]       sum;
	logic [SEEK_W-1:0]   total_q;

	// one subtract, borrow gives the compare
	always_comb begin
		diff = {1'b0, a} - {1'b0, b};
		lt   = diff[HW];
		absd = lt ? HW'(~diff[HW-1:0] + HW'(1)) : diff[HW-1:0];
		sum  = SW'(total_q) + SW'(absd);
	end

	// saturating accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctl.clr) begin
			total_q <= '0;
		end else if (ctl.acc) begin
			total_q <= (sum > SW'(SEEK_MAX)) ? SEEK_MAX : sum[SEEK_W-1:0];
		end
	end

	assign total = total_q;

endmodule

/* rtl/dss_seq.sv */
// ----------------------------------------------------------------------------
// dss_seq
// Sequencer: sorted insertion of each request by shifting larger entries up
// one per cycle, then on the last request the split search and the walk legs
// through the shared distance unit.
// ----------------------------------------------------------------------------
module dss_seq import dss_pkg::*; #(
	parameter int unsigned MAX_REQUESTS = 64,
	parameter int unsigned CYL_BITS     = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request transaction
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [CYL_IN_W-1:0]             cylinder,
	input  logic                            last_request,
	// configuration
	input  mode_t                           mode,
	input  logic [CFG_DATA_W-1:0]           start_head,
	input  logic [CFG_DATA_W-1:0]           disk_end,
	// store
	output logic                            mem_we,
	output logic [$clog2(MAX_REQUESTS)-1:0] mem_waddr,
	output logic [CYL_BITS-1:0]             mem_wdata,
	output logic [$clog2(MAX_REQUESTS)-1:0] mem_raddr,
	input  logic [CYL_BITS-1:0]             mem_rdata,
	// shared distance unit
	output leg_ctl_t                        leg_ctl,
	output logic [((CYL_BITS > CYL_IN_W) ? CYL_BITS : CYL_IN_W)-1:0] leg_a,
	output logic [((CYL_BITS > CYL_IN_W) ? CYL_BITS : CYL_IN_W)-1:0] leg_b,
	input  logic                            leg_lt,
	// result hand-off
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [COUNT_W-1:0]              served_count,
	output logic                            overflow
);

	localparam int unsigned AW = $clog2(MAX_REQUESTS);
	localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
	localparam int unsigned DW = CYL_BITS;
	localparam int unsigned HW = (CYL_BITS > CYL_IN_W) ? CYL_BITS : CYL_IN_W;

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_s1;
	logic          vld_s1;
	logic [CW-1:0] split_q;
	logic [HW-1:0] head_q;
	logic [DW-1:0] cyl_q;
	logic          last_q;

	logic          accept;
	logic          full;
	logic          desc;
	logic          issue;
	logic          found;
	logic          ins_done;
	logic          stream_end;
	logic [DW-1:0] cyl_in;

	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(MAX_REQUESTS));
	assign desc     = (mode == MODE_SCAN) || (mode == MODE_LOOK);
	assign cyl_in   = DW'(cylinder);
	assign ins_done = (pos_q == '0) || !leg_lt;
	assign found    = vld_s1 && !leg_lt;

	// read issue for the streaming phases
	always_comb begin
		issue = 1'b0;
		unique case (state_q)
			ST_SPLIT: issue = (idx_q < count_q) && !found;
			ST_UP:    issue = (idx_q < count_q);
			ST_LOW:   issue = desc ? (idx_q != '0) : (idx_q < split_q);
			default:  issue = 1'b0;
		endcase
	end

	assign stream_end = !issue && !vld_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (full || count_q == '0) begin
						state_d = last_request ? ST_SPLIT : ST_IDLE;
					end else begin
						state_d = ST_INS;
					end
				end
			end
			ST_INS: begin
				if (ins_done) begin
					state_d = last_q ? ST_SPLIT : ST_IDLE;
				end
			end
			ST_SPLIT: begin
				if (found || (!vld_s1 && idx_q >= count_q)) begin
					state_d = ST_UP;
				end
			end
			ST_UP: begin
				if (stream_end) begin
					state_d = (mode == MODE_SCAN || mode == MODE_CSCAN) ? ST_SWEEP : ST_LOW;
				end
			end
			ST_SWEEP: state_d = (mode == MODE_CSCAN) ? ST_JUMP : ST_LOW;
			ST_JUMP:  state_d = ST_LOW;
			ST_LOW: begin
				if (stream_end) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: store access, distance unit operands, handshakes
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		res_valid = (state_q == ST_RESULT);
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = cyl_q;
		mem_raddr = idx_q[AW-1:0];
		leg_a     = head_q;
		leg_b     = HW'(mem_rdata);
		leg_ctl   = '0;
		unique case (state_q)
			ST_IDLE: begin
				// prefetch the top entry for the compare of the next request
				mem_raddr = AW'(count_q - CW'(1));
				if (accept && !full && count_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = cyl_in;
				end
			end
			ST_INS: begin
				mem_raddr = AW'(32'(pos_q) - 32'd2);
				leg_a     = HW'(cyl_q);
				mem_we    = 1'b1;
				mem_wdata = ins_done ? cyl_q : mem_rdata;
			end
			ST_SPLIT: begin
				leg_a = HW'(mem_rdata);
				leg_b = HW'(start_head);
			end
			ST_UP: begin
				leg_ctl.acc = vld_s1;
			end
			ST_SWEEP: begin
				leg_b       = HW'(disk_end);
				leg_ctl.acc = 1'b1;
			end
			ST_JUMP: begin
				leg_b       = '0;
				leg_ctl.acc = 1'b1;
			end
			ST_LOW: begin
				if (desc) begin
					mem_raddr = AW'(idx_q - CW'(1));
				end
				leg_ctl.acc = vld_s1;
			end
			ST_RESULT: begin
				leg_ctl.clr = res_ready;
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// batch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			vld_s1    <= 1'b0;
			idx_q     <= '0;
		end else begin
			vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else if (count_q == '0) begin
							count_q <= CW'(1);
						end
					end
				end
				ST_INS: begin
					idx_q <= '0;
					if (ins_done) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_SPLIT: begin
					if (found) begin
						idx_q <= idx_s1;
					end else if (issue) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_UP: begin
					if (issue) begin
						idx_q <= idx_q + CW'(1);
					end else if (stream_end) begin
						idx_q <= desc ? split_q : '0;
					end
				end
				ST_SWEEP, ST_JUMP: begin
					idx_q <= desc ? split_q : '0;
				end
				ST_LOW: begin
					if (issue) begin
						idx_q <= desc ? (idx_q - CW'(1)) : (idx_q + CW'(1));
					end
				end
				ST_RESULT: begin
					if (res_ready) begin
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cyl_q  <= cyl_in;
					last_q <= last_request;
					pos_q  <= AW'(count_q);
				end
			end
			ST_INS: begin
				if (!ins_done) begin
					pos_q <= pos_q - AW'(1);
				end
			end
			ST_SPLIT: begin
				head_q <= HW'(start_head);
				if (found) begin
					split_q <= idx_s1;
				end else begin
					split_q <= count_q;
				end
			end
			ST_UP, ST_LOW: begin
				if (vld_s1) begin
					head_q <= HW'(mem_rdata);
				end
			end
			ST_SWEEP: head_q <= HW'(disk_end);
			ST_JUMP:  head_q <= '0;
			default: ;
		endcase
	end

	// result fields
	assign served_count = (32'(count_q) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_q);
	assign overflow     = dropped_q;

endmodule

/* rtl/disk_seek_distance_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// disk_seek_distance_scheduler_unit
// Collects a batch of cylinder requests in ascending order and, on the last
// request, reports the total head travel for SCAN, LOOK, C-SCAN or C-LOOK.
// ----------------------------------------------------------------------------
// Usage:
//   req : one cylinder per transaction; last_request closes the batch.
//   cfg : writes mode, start_head or disk_end by index; take writes only
//         while no batch is in flight. cfg.ready is always high.
//   res : one transaction per batch with total_seek, served_count, overflow.
// Operation:
//   a request into a non-empty store is placed by the sorted insertion,
//   in which the single store write port moves one entry per cycle; the
//   first request of a batch and a dropped one need no insertion.
//   The last request adds the walk: one store read per entry for the
//   split search and one per served entry, each leg summed by the one
//   shared subtractor.
//   req.ready is low while an item is in work.
// Requests beyond MAX_REQUESTS are dropped and flagged in overflow.
// Reset clears the batch, sets mode SCAN, start_head 0 and disk_end 499.
// A result waits in an output register; the next batch is taken meanwhile,
// and only the following result waits for res.ready.
// ----------------------------------------------------------------------------
module disk_seek_distance_scheduler_unit import dss_pkg::*; #(
	parameter int unsigned MAX_REQUESTS = 64,
	parameter int unsigned CYL_BITS     = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	dss_req_if.sink      req,
	dss_res_if.source    res,
	dss_cfg_if.sink      cfg
);

	localparam int unsigned AW = $clog2(MAX_REQUESTS);
	localparam int unsigned HW = (CYL_BITS > CYL_IN_W) ? CYL_BITS : CYL_IN_W;

	mode_t                 mode_q;
	logic [CFG_DATA_W-1:0] start_head_q;
	logic [CFG_DATA_W-1:0] disk_end_q;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [CYL_BITS-1:0]   mem_wdata;
	logic [AW-1:0]         mem_raddr;
	logic [CYL_BITS-1:0]   mem_rdata;

	leg_ctl_t              leg_ctl;
	logic [HW-1:0]         leg_a;
	logic [HW-1:0]         leg_b;
	logic                  leg_lt;
	logic [SEEK_W-1:0]     total;

	logic                  res_valid;
	logic                  res_ready;
	logic [COUNT_W-1:0]    served_count;
	logic                  overflow;

	logic                  out_valid_q;
	logic [SEEK_W-1:0]     out_total_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic                  out_ovf_q;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_SCAN;
			start_head_q <= '0;
			disk_end_q   <= DISK_END_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_MODE:       mode_q       <= mode_t'(cfg.data[1:0]);
				CFG_START_HEAD: start_head_q <= cfg.data;
				CFG_DISK_END:   disk_end_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// request store
	dss_store #(
		.DEPTH (MAX_REQUESTS),
		.DW    (CYL_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// shared compare and distance unit
	dss_leg_unit #(
		.HW (HW)
	) u_leg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (leg_ctl),
		.a      (leg_a),
		.b      (leg_b),
		.lt     (leg_lt),
		.total  (total)
	);

	// sequencer
	dss_seq #(
		.MAX_REQUESTS (MAX_REQUESTS),
		.CYL_BITS     (CYL_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.cylinder     (req.cylinder),
		.last_request (req.last_request),
		.mode         (mode_q),
		.start_head   (start_head_q),
		.disk_end     (disk_end_q),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.leg_ctl      (leg_ctl),
		.leg_a        (leg_a),
		.leg_b        (leg_b),
		.leg_lt       (leg_lt),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.served_count (served_count),
		.overflow     (overflow)
	);

	// output register
	assign res_ready = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_total_q <= total;
			out_count_q <= served_count;
			out_ovf_q   <= overflow;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.total_seek   = out_total_q;
	assign res.served_count = out_count_q;
	assign res.overflow     = out_ovf_q;

endmodule
